FILE: sv/urb_pkg.sv
// Shared types and constants for the UART receive/transmit rings.
// Holds request codes, event codes, ring sizes, item structs and the command decode.
// No dependencies.
`timescale 1ns / 1ps

package urb_pkg;

   // Ring sizes are powers of two, so pointers wrap by plain overflow.
   localparam int RX_SLOTS = 128;
   localparam int TX_SLOTS = 64;
   localparam int RX_AW    = $clog2(RX_SLOTS);
   localparam int TX_AW    = $clog2(TX_SLOTS);

   localparam logic [7:0] ASCII_MAX = 8'h7F;

   typedef enum logic [2:0] {
      REQ_LINE_RX  = 3'd0,
      REQ_HOST_RD  = 3'd1,
      REQ_HOST_WR  = 3'd2,
      REQ_TX_READY = 3'd3,
      REQ_RX_FLUSH = 3'd4
   } req_code_type;

   // Real-time command bytes
   localparam logic [7:0] CMD_ABORT      = 8'h18;
   localparam logic [7:0] CMD_STATUS     = 8'h3F;
   localparam logic [7:0] CMD_START      = 8'h7E;
   localparam logic [7:0] CMD_HOLD       = 8'h21;
   localparam logic [7:0] CMD_DOOR       = 8'h84;
   localparam logic [7:0] CMD_JOG_STOP   = 8'h85;
   localparam logic [7:0] CMD_FEED_RESET = 8'h90;
   localparam logic [7:0] CMD_FEED_PLUS  = 8'h91;
   localparam logic [7:0] CMD_FEED_MINUS = 8'h92;
   localparam logic [7:0] CMD_RAPID_RST  = 8'h95;

   // Event codes
   localparam logic [3:0] EV_NONE       = 4'd0;
   localparam logic [3:0] EV_RESET      = 4'd1;
   localparam logic [3:0] EV_STATUS     = 4'd2;
   localparam logic [3:0] EV_START      = 4'd3;
   localparam logic [3:0] EV_HOLD       = 4'd4;
   localparam logic [3:0] EV_DOOR       = 4'd5;
   localparam logic [3:0] EV_JOG_CANCEL = 4'd6;
   localparam logic [3:0] EV_FEED_RESET = 4'd7;
   localparam logic [3:0] EV_FEED_PLUS  = 4'd8;
   localparam logic [3:0] EV_FEED_MINUS = 4'd9;
   localparam logic [3:0] EV_RAPID_RST  = 4'd10;

   // Output byte source for the stage that waits on ring read data
   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_RX   = 2'd1,
      SRC_TX   = 2'd2
   } byte_src_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] data;
      logic       jog_active;
   } req_item_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             out_valid;
      logic [3:0]       event_res;
      logic             accepted;
      logic             tx_active;
      logic [RX_AW-1:0] rx_count;
      logic [RX_AW-1:0] rx_free;
      logic [TX_AW-1:0] tx_count;
   } rsp_item_type;

   function automatic logic is_rt_code(input logic [7:0] b);
      return (b == CMD_ABORT) || (b == CMD_STATUS) || (b == CMD_START) || (b == CMD_HOLD);
   endfunction

   function automatic logic [3:0] rt_event(input logic [7:0] b, input logic jog);
      logic [3:0] ev;
      case (b)
         CMD_ABORT:      ev = EV_RESET;
         CMD_STATUS:     ev = EV_STATUS;
         CMD_START:      ev = EV_START;
         CMD_HOLD:       ev = EV_HOLD;
         CMD_DOOR:       ev = EV_DOOR;
         CMD_JOG_STOP:   ev = jog ? EV_JOG_CANCEL : EV_NONE;
         CMD_FEED_RESET: ev = EV_FEED_RESET;
         CMD_FEED_PLUS:  ev = EV_FEED_PLUS;
         CMD_FEED_MINUS: ev = EV_FEED_MINUS;
         CMD_RAPID_RST:  ev = EV_RAPID_RST;
         default:        ev = EV_NONE;
      endcase
      return ev;
   endfunction

endpackage

FILE: sv/urb_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read data is registered on rd_en and holds until the next read.
// No dependencies.
`timescale 1ns / 1ps

module urb_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/uart_ring_buffers_realtime_filter.sv
// UART receive/transmit byte rings with a real-time command filter.
// Uses urb_pkg for types and command decode, urb_ram for the two ring stores.
//
// Input channel (req_valid/req_stall/req_item): one item per request: a line
// byte, a host read, a host write, transmitter ready or a receive flush.
// Result channel (rsp_valid/rsp_stall/rsp_item): exactly one result per item,
// in order, carrying the popped byte (if any), the real-time event, the store
// status and the ring counts after the request.
// Pointers update at the edge that accepts the item; the ring memory is read
// at the same edge into its read register, beside the holding stage, and the
// read data joins the result as it passes from there to the output register;
// rsp_valid rises with it. One item per cycle is taken while req_stall is low,
// as each pointer update and each ring memory read is done at the accepting edge.
// When the receiver stalls, the output register holds the result, the holding
// stage keeps the next, and req_stall rises while both are full and stalled.
// Reset (synchronous) empties both rings, clears the transmit-busy flag and
// drops any item in flight. Ring memory contents are not cleared: only
// entries between tail and head are ever read. Each ring keeps one slot empty.
`timescale 1ns / 1ps

module uart_ring_buffers_realtime_filter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  urb_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output urb_pkg::rsp_item_type rsp_item
);

   localparam int RX_AW = urb_pkg::RX_AW;
   localparam int TX_AW = urb_pkg::TX_AW;

   logic [RX_AW-1:0] rx_head_ff, rx_head_in;
   logic [RX_AW-1:0] rx_tail_ff, rx_tail_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in;
   logic [TX_AW-1:0] tx_tail_ff, tx_tail_in;
   logic             tx_busy_ff, tx_busy_in;

   logic                  s1_valid_ff;
   urb_pkg::rsp_item_type s1_item_ff, s1_item_in;
   urb_pkg::byte_src_type s1_src_ff, s1_src_in;
   logic                  s1_move;

   logic                  rsp_valid_ff;
   urb_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic accept;
   logic rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [RX_AW-1:0] rx_next, rx_cnt;
   logic [TX_AW-1:0] tx_next, tx_cnt;
   logic [6:0] rx_rd_data;
   logic [7:0] tx_rd_data;
   logic [7:0] din;

   urb_ram #(.DEPTH(urb_pkg::RX_SLOTS), .WIDTH(7)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_head_ff),
      .wr_data (din[6:0]),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_tail_ff),
      .rd_data (rx_rd_data)
   );

   urb_ram #(.DEPTH(urb_pkg::TX_SLOTS), .WIDTH(8)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_head_ff),
      .wr_data (din),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_tail_ff),
      .rd_data (tx_rd_data)
   );

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;
   assign din       = req_item.data;
   assign rx_next   = rx_head_ff + 1'b1;
   assign tx_next   = tx_head_ff + 1'b1;

   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      tx_busy_in = tx_busy_ff;
      rx_wr_en   = 1'b0;
      rx_rd_en   = 1'b0;
      tx_wr_en   = 1'b0;
      tx_rd_en   = 1'b0;
      s1_src_in  = urb_pkg::SRC_NONE;
      s1_item_in = '0;

      case (urb_pkg::req_code_type'(req_item.req_type))
         urb_pkg::REQ_LINE_RX: begin
            if (urb_pkg::is_rt_code(din) || din > urb_pkg::ASCII_MAX) begin
               s1_item_in.event_res = urb_pkg::rt_event(din, req_item.jog_active);
            end else if (rx_next != rx_tail_ff) begin
               rx_wr_en            = accept;
               rx_head_in          = rx_next;
               s1_item_in.accepted = 1'b1;
            end
         end
         urb_pkg::REQ_HOST_RD: begin
            if (rx_head_ff != rx_tail_ff) begin
               rx_rd_en             = accept;
               rx_tail_in           = rx_tail_ff + 1'b1;
               s1_src_in            = urb_pkg::SRC_RX;
               s1_item_in.out_valid = 1'b1;
            end
         end
         urb_pkg::REQ_HOST_WR: begin
            if (tx_next != tx_tail_ff) begin
               tx_wr_en            = accept;
               tx_head_in          = tx_next;
               tx_busy_in          = 1'b1;
               s1_item_in.accepted = 1'b1;
            end
         end
         urb_pkg::REQ_TX_READY: begin
            if (tx_busy_ff && tx_head_ff != tx_tail_ff) begin
               tx_rd_en             = accept;
               tx_tail_in           = tx_tail_ff + 1'b1;
               s1_src_in            = urb_pkg::SRC_TX;
               s1_item_in.out_valid = 1'b1;
            end
            if (tx_tail_in == tx_head_ff) begin
               tx_busy_in = 1'b0;
            end
         end
         urb_pkg::REQ_RX_FLUSH: begin
            rx_tail_in = rx_head_ff;
         end
         default: begin
         end
      endcase

      // power-of-two rings: the difference wraps to the count
      rx_cnt = rx_head_in - rx_tail_in;
      tx_cnt = tx_head_in - tx_tail_in;
      s1_item_in.tx_active = tx_busy_in;
      s1_item_in.rx_count  = rx_cnt;
      s1_item_in.rx_free   = RX_AW'(urb_pkg::RX_SLOTS - 1) - rx_cnt;
      s1_item_in.tx_count  = tx_cnt;
   end

   // merge ring read data into the result as it leaves the holding stage
   always_comb begin
      rsp_item_in = s1_item_ff;
      case (s1_src_ff)
         urb_pkg::SRC_RX:   rsp_item_in.out_byte = {1'b0, rx_rd_data};
         urb_pkg::SRC_TX:   rsp_item_in.out_byte = tx_rd_data;
         urb_pkg::SRC_NONE: rsp_item_in.out_byte = '0;
         default:           rsp_item_in.out_byte = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_busy_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rx_head_ff <= rx_head_in;
            rx_tail_ff <= rx_tail_in;
            tx_head_ff <= tx_head_in;
            tx_tail_ff <= tx_tail_in;
            tx_busy_ff <= tx_busy_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
         s1_src_ff  <= s1_src_in;
      end
      if (s1_move) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for uart_ring_buffers_realtime_filter: a clocked driver, a monitor
// and an in-line predictor of both byte rings and the real-time command filter.
// Depends on urb_pkg (item structs, request, command and event codes) and the block itself.
`timescale 1ns / 1ps

module testbench;

   localparam int RX_SLOTS = urb_pkg::RX_SLOTS;
   localparam int TX_SLOTS = urb_pkg::TX_SLOTS;
   localparam int RX_AW    = urb_pkg::RX_AW;
   localparam int TX_AW    = urb_pkg::TX_AW;

   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   // traffic shapes for the random bursts
   localparam int MODE_FILL_RX  = 0;
   localparam int MODE_DRAIN_RX = 1;
   localparam int MODE_FILL_TX  = 2;
   localparam int MODE_DRAIN_TX = 3;
   localparam int MODE_MIXED    = 4;

   localparam int RANDOM_ITEMS = 650;
   localparam int QUIET_TAIL   = 100;
   localparam int LONG_HOLD_AT = 250;
   localparam int LONG_HOLD    = 200;

   typedef struct {
      urb_pkg::req_item_type item;
      bit                    drain_first;
   } line_request_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   urb_pkg::req_item_type req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   urb_pkg::rsp_item_type rsp_item;

   line_request_type      request_q[$];
   urb_pkg::rsp_item_type predicted_rsp_q[$];

   // predictor copy of the rings
   logic [7:0]       rx_mem [RX_SLOTS];
   logic [7:0]       tx_mem [TX_SLOTS];
   logic [RX_AW-1:0] rx_wr_ptr, rx_rd_ptr;
   logic [TX_AW-1:0] tx_wr_ptr, tx_rd_ptr;
   logic             tx_busy;

   int n_planned   = 0;
   int n_accepted  = 0;
   int n_results   = 0;
   int n_errors    = 0;
   int send_gap    = 0;
   int stall_left  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;

   uart_ring_buffers_realtime_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [3:0] command_event(input logic [7:0] b, input logic jog);
      logic [3:0] ev;
      case (b)
         urb_pkg::CMD_ABORT:      ev = urb_pkg::EV_RESET;
         urb_pkg::CMD_STATUS:     ev = urb_pkg::EV_STATUS;
         urb_pkg::CMD_START:      ev = urb_pkg::EV_START;
         urb_pkg::CMD_HOLD:       ev = urb_pkg::EV_HOLD;
         urb_pkg::CMD_DOOR:       ev = urb_pkg::EV_DOOR;
         urb_pkg::CMD_JOG_STOP:   ev = jog ? urb_pkg::EV_JOG_CANCEL : urb_pkg::EV_NONE;
         urb_pkg::CMD_FEED_RESET: ev = urb_pkg::EV_FEED_RESET;
         urb_pkg::CMD_FEED_PLUS:  ev = urb_pkg::EV_FEED_PLUS;
         urb_pkg::CMD_FEED_MINUS: ev = urb_pkg::EV_FEED_MINUS;
         urb_pkg::CMD_RAPID_RST:  ev = urb_pkg::EV_RAPID_RST;
         default:                 ev = urb_pkg::EV_NONE;
      endcase
      return ev;
   endfunction

   // Apply one accepted item to the ring copies and return the result it gives.
   function automatic urb_pkg::rsp_item_type compute_ring_result(
      input urb_pkg::req_item_type it);
      urb_pkg::rsp_item_type r;
      logic [3:0]            ev;
      logic [RX_AW-1:0]      rx_next;
      logic [TX_AW-1:0]      tx_next;
      logic [RX_AW-1:0]      rx_used;
      r = '0;
      rx_next = rx_wr_ptr + 1'b1;
      tx_next = tx_wr_ptr + 1'b1;
      case (it.req_type)
         urb_pkg::REQ_LINE_RX: begin
            ev = command_event(it.data, it.jog_active);
            // commands and bytes above ASCII never reach the ring
            if (it.data > urb_pkg::ASCII_MAX || ev != urb_pkg::EV_NONE) begin
               r.event_res = ev;
            end else if (rx_next != rx_rd_ptr) begin
               rx_mem[rx_wr_ptr] = it.data;
               rx_wr_ptr = rx_next;
               r.accepted = 1'b1;
            end
         end
         urb_pkg::REQ_HOST_RD: begin
            if (rx_wr_ptr != rx_rd_ptr) begin
               r.out_byte = rx_mem[rx_rd_ptr];
               r.out_valid = 1'b1;
               rx_rd_ptr = rx_rd_ptr + 1'b1;
            end
         end
         urb_pkg::REQ_HOST_WR: begin
            if (tx_next != tx_rd_ptr) begin
               tx_mem[tx_wr_ptr] = it.data;
               tx_wr_ptr = tx_next;
               tx_busy = 1'b1;
               r.accepted = 1'b1;
            end
         end
         urb_pkg::REQ_TX_READY: begin
            if (tx_busy && tx_wr_ptr != tx_rd_ptr) begin
               r.out_byte = tx_mem[tx_rd_ptr];
               r.out_valid = 1'b1;
               tx_rd_ptr = tx_rd_ptr + 1'b1;
            end
            if (tx_rd_ptr == tx_wr_ptr) begin
               tx_busy = 1'b0;
            end
         end
         urb_pkg::REQ_RX_FLUSH: begin
            rx_rd_ptr = rx_wr_ptr;
         end
         default: begin
         end
      endcase
      rx_used = rx_wr_ptr - rx_rd_ptr;
      r.tx_active = tx_busy;
      r.rx_count = rx_used;
      r.rx_free = RX_AW'(RX_SLOTS - 1) - rx_used;
      r.tx_count = tx_wr_ptr - tx_rd_ptr;
      return r;
   endfunction

   function automatic logic [7:0] random_command_byte();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0:       b = urb_pkg::CMD_ABORT;
         1:       b = urb_pkg::CMD_STATUS;
         2:       b = urb_pkg::CMD_START;
         3:       b = urb_pkg::CMD_HOLD;
         4:       b = urb_pkg::CMD_DOOR;
         5:       b = urb_pkg::CMD_JOG_STOP;
         6:       b = urb_pkg::CMD_FEED_RESET;
         7:       b = urb_pkg::CMD_FEED_PLUS;
         8:       b = urb_pkg::CMD_FEED_MINUS;
         default: b = urb_pkg::CMD_RAPID_RST;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] random_line_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 8'($urandom_range(0, 127));
      if (roll < 80) return random_command_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic urb_pkg::req_item_type random_request(input int mode);
      urb_pkg::req_item_type it;
      int                    roll;
      roll = $urandom_range(0, 99);
      it.data = 8'($urandom_range(0, 255));
      it.jog_active = 1'($urandom_range(0, 1));
      case (mode)
         MODE_FILL_RX: begin
            if (roll < 85)      it.req_type = urb_pkg::REQ_LINE_RX;
            else if (roll < 95) it.req_type = urb_pkg::REQ_HOST_RD;
            else                it.req_type = urb_pkg::REQ_HOST_WR;
         end
         MODE_DRAIN_RX: begin
            if (roll < 70)      it.req_type = urb_pkg::REQ_HOST_RD;
            else if (roll < 85) it.req_type = urb_pkg::REQ_LINE_RX;
            else if (roll < 90) it.req_type = urb_pkg::REQ_RX_FLUSH;
            else                it.req_type = urb_pkg::REQ_HOST_WR;
         end
         MODE_FILL_TX: begin
            if (roll < 75)      it.req_type = urb_pkg::REQ_HOST_WR;
            else if (roll < 88) it.req_type = urb_pkg::REQ_TX_READY;
            else                it.req_type = urb_pkg::REQ_LINE_RX;
         end
         MODE_DRAIN_TX: begin
            if (roll < 70)      it.req_type = urb_pkg::REQ_TX_READY;
            else if (roll < 85) it.req_type = urb_pkg::REQ_HOST_WR;
            else                it.req_type = urb_pkg::REQ_HOST_RD;
         end
         default: begin
            if (roll < 30)      it.req_type = urb_pkg::REQ_LINE_RX;
            else if (roll < 50) it.req_type = urb_pkg::REQ_HOST_RD;
            else if (roll < 70) it.req_type = urb_pkg::REQ_HOST_WR;
            else if (roll < 90) it.req_type = urb_pkg::REQ_TX_READY;
            else if (roll < 95) it.req_type = urb_pkg::REQ_RX_FLUSH;
            else it.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
         end
      endcase
      if (it.req_type == urb_pkg::REQ_LINE_RX) begin
         it.data = (mode == MODE_FILL_RX && roll < 80) ? 8'($urandom_range(0, 127))
                                                       : random_line_byte();
      end
      return it;
   endfunction

   task automatic queue_request(input logic [2:0] kind, input logic [7:0] b, input logic jog);
      line_request_type lr;
      lr.item.req_type = kind;
      lr.item.data = b;
      lr.item.jog_active = jog;
      lr.drain_first = 1'b0;
      request_q.push_back(lr);
   endtask

   task automatic report_error(input string what);
      n_errors++;
      if (n_errors <= 10) begin
         $display("ERROR result %0d: %s", n_results, what);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         report_error($sformatf("%s expected 0x%02h, got 0x%02h", name, want, got));
      end
   endtask

   // Driver: predict each accepted item, then offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         rx_wr_ptr = '0;
         rx_rd_ptr = '0;
         tx_wr_ptr = '0;
         tx_rd_ptr = '0;
         tx_busy = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsp_q.push_back(compute_ring_result(req_item));
            n_accepted <= n_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_q.size() > 0 &&
                         !(request_q[0].drain_first && predicted_rsp_q.size() > 0 &&
                           n_accepted < n_planned - QUIET_TAIL)) begin
               req_item <= request_q[0].item;
               req_valid <= 1'b1;
               request_q.pop_front();
               if (n_accepted < n_planned - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
                  send_gap = $urandom_range(1, 4);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: short random bursts, plus one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_accepted >= LONG_HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (n_accepted < n_planned - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each accepted result with the oldest prediction.
   always @(posedge clock) begin : monitor
      urb_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsp_q.size() == 0) begin
            report_error("result with no item outstanding");
         end else begin
            want = predicted_rsp_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_item.out_byte);
            check_field("out_valid", want.out_valid, rsp_item.out_valid);
            check_field("event_res", want.event_res, rsp_item.event_res);
            check_field("accepted", want.accepted, rsp_item.accepted);
            check_field("tx_active", want.tx_active, rsp_item.tx_active);
            check_field("rx_count", want.rx_count, rsp_item.rx_count);
            check_field("rx_free", want.rx_free, rsp_item.rx_free);
            check_field("tx_count", want.tx_count, rsp_item.tx_count);
         end
         n_results++;
      end
   end

   initial begin
      int n_random;
      int mode;
      int burst;
      int burst_no;
      line_request_type lr;

      // empty rings first, then every command code, the byte extremes and the other requests
      queue_request(urb_pkg::REQ_HOST_RD, 8'h00, 1'b0);
      queue_request(urb_pkg::REQ_TX_READY, 8'hFF, 1'b1);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_ABORT, 1'b0);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_STATUS, 1'b1);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_START, 1'b0);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_HOLD, 1'b1);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_DOOR, 1'b0);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_JOG_STOP, 1'b0);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_JOG_STOP, 1'b1);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_FEED_RESET, 1'b0);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_FEED_PLUS, 1'b1);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_FEED_MINUS, 1'b0);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::CMD_RAPID_RST, 1'b1);
      queue_request(urb_pkg::REQ_LINE_RX, 8'h00, 1'b0);
      queue_request(urb_pkg::REQ_LINE_RX, urb_pkg::ASCII_MAX, 1'b1);
      queue_request(urb_pkg::REQ_LINE_RX, 8'h80, 1'b0);
      queue_request(urb_pkg::REQ_LINE_RX, 8'hFF, 1'b1);
      queue_request(urb_pkg::REQ_HOST_RD, 8'hFF, 1'b1);
      queue_request(urb_pkg::REQ_HOST_WR, 8'h00, 1'b0);
      queue_request(urb_pkg::REQ_HOST_WR, 8'hFF, 1'b1);
      queue_request(urb_pkg::REQ_TX_READY, 8'h00, 1'b0);
      queue_request(urb_pkg::REQ_TX_READY, 8'h00, 1'b0);
      queue_request(urb_pkg::REQ_TX_READY, 8'h00, 1'b1);
      queue_request(urb_pkg::REQ_RX_FLUSH, 8'hA5, 1'b1);
      queue_request(REQ_UNUSED_LO, 8'h5A, 1'b0);
      queue_request(REQ_UNUSED_HI, 8'hFF, 1'b1);

      // fill both rings past full first, then random bursts of varying shape
      n_random = 0;
      burst_no = 0;
      while (n_random < RANDOM_ITEMS) begin
         if (burst_no == 0) begin
            mode = MODE_FILL_RX;
            burst = 150;
         end else if (burst_no == 1) begin
            mode = MODE_FILL_TX;
            burst = 75;
         end else begin
            mode = $urandom_range(MODE_FILL_RX, MODE_MIXED);
            burst = $urandom_range(20, 60);
         end
         for (int i = 0; i < burst; i++) begin
            lr.item = random_request(mode);
            if (burst_no == 0 && i < 140) begin
               lr.item.req_type = urb_pkg::REQ_LINE_RX;
               lr.item.data = 8'($urandom_range(0, 127));
            end else if (burst_no == 1 && i < 70) begin
               lr.item.req_type = urb_pkg::REQ_HOST_WR;
            end
            // pause the sender now and then until every result is back
            lr.drain_first = (i == 0) && (burst_no == 0 || $urandom_range(0, 3) == 0);
            request_q.push_back(lr);
            n_random++;
         end
         burst_no++;
      end
      n_planned = request_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() > 0 || req_valid || predicted_rsp_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (n_errors == 0 && predicted_rsp_q.size() == 0) begin
         $display("uart_ring_buffers_realtime_filter regression: pass");
      end else begin
         $display("uart_ring_buffers_realtime_filter regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("uart_ring_buffers_realtime_filter regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
sv/urb_pkg.sv
sv/urb_ram.sv
sv/uart_ring_buffers_realtime_filter.sv
tb/sv/testbench.sv
